### src/csc_pkg.sv
// Shared types, constants and table functions of the cascaded stereo compressor.
`default_nettype none

package csc_pkg;

    localparam int STAGES      = 4;
    localparam int SAMPLE_BITS = 24;

    localparam int STAGE_W    = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int ENV_W      = SAMPLE_BITS + 12;
    localparam int SUM_W      = SAMPLE_BITS + 1;
    localparam int NORM_STEPS = $clog2(ENV_W);
    localparam int NCNT_W     = (NORM_STEPS > 1) ? $clog2(NORM_STEPS) : 1;
    localparam int LOG_W      = NORM_STEPS + 16;
    localparam int GAIN_W     = 17;
    localparam int MAKEUP_W   = 15;
    localparam int PROD_W     = GAIN_W + MAKEUP_W;
    localparam int MUL_W      = SAMPLE_BITS + PROD_W + 1;
    localparam int SCL_W      = MUL_W - 28;
    localparam int CFG_IDX_W  = $clog2(STAGES + 1);
    localparam int CFG_DATA_W = 64;
    localparam int GAIN_SHIFT_LIM = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STAGE0 = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] SETTINGS_RESET = 64'h1000_FFFF_F7C0_0000;

    typedef struct packed {
        logic                   instant;
        logic [MAKEUP_W-1:0]    makeup;
        logic [11:0]            release_pole;
        logic [11:0]            attack_pole;
        logic [7:0]             slope;
        logic [15:0]            threshold;
    } t_settings;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_sample_in;
        logic                          block_end_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          block_end_out;
    } t_out;

    localparam logic [16:0] LOG2_TAB [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
        17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
        17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    localparam logic [17:0] EXP2_TAB [17] = '{
        18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
        18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105544,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    // Interpolated log2 of the mantissa fraction f, Q0.16 in, Q.16 out.
    function automatic logic [16:0] log2_interp(input logic [15:0] f);
        logic [4:0]  i;
        logic [16:0] diff;
        logic [28:0] prod;
        i    = {1'b0, f[15:12]};
        diff = LOG2_TAB[i + 5'd1] - LOG2_TAB[i];
        prod = diff * f[11:0];
        return LOG2_TAB[i] + 17'(prod >> 12);
    endfunction

    // Interpolated 2^u for u in Q0.16, result Q.16.
    function automatic logic [17:0] exp2_interp(input logic [15:0] u);
        logic [4:0]  i;
        logic [17:0] diff;
        logic [29:0] prod;
        i    = {1'b0, u[15:12]};
        diff = EXP2_TAB[i + 5'd1] - EXP2_TAB[i];
        prod = diff * u[11:0];
        return EXP2_TAB[i] + 18'(prod >> 12);
    endfunction

    // Saturates a scaled sample to the signed sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SCL_W-1:0] v);
        logic signed [SCL_W-1:0] hi;
        logic signed [SCL_W-1:0] lo;
        hi = SCL_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - SCL_W'(1);
        if (v > hi) begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### src/cascaded_stereo_compressor.sv
// Top level of the cascaded stereo compressor: sequencer, envelope memory and datapath.
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  -------------------------
//  in        input      i_in_valid / o_in_ready        csc_pkg::t_in  i_in_data
//  out       output     o_out_valid / i_out_ready      csc_pkg::t_out o_out_data
//  cfg       input      i_cfg_wr_en (no wait)          i_cfg_idx, i_cfg_data
//
// One sample pair is worked on at a time. In the worst case each enabled stage does a
// level and envelope read, two follower multiplies, a six step leading zero search,
// log, slope, exp, makeup and two scaling multiplies, fewer steps when the gain stage
// is bypassed; a disabled block goes from idle straight to the done state. The
// envelope memory is read once per stage and written at most once per stage, in order,
// so no two accesses to one entry ever overlap. Reset is synchronous and active low;
// it restores the register defaults and marks all envelope entries as zero through
// per-entry valid bits. A finished result waits in the output register, and a new
// transfer is accepted meanwhile; only the hand-over to the output register stalls.
`default_nettype none

module cascaded_stereo_compressor (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  csc_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output csc_pkg::t_out                       o_out_data,
    input  wire                                 i_cfg_wr_en,
    input  wire  [csc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [csc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_LEVEL   = 12'b0000_0000_0010,
        S_ENV_MUL = 12'b0000_0000_0100,
        S_ENV_UPD = 12'b0000_0000_1000,
        S_NORM    = 12'b0000_0001_0000,
        S_LOG     = 12'b0000_0010_0000,
        S_SLOPE   = 12'b0000_0100_0000,
        S_EXP     = 12'b0000_1000_0000,
        S_PROD    = 12'b0001_0000_0000,
        S_MUL_L   = 12'b0010_0000_0000,
        S_MUL_R   = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    localparam int ENV_W  = csc_pkg::ENV_W;
    localparam int SB     = csc_pkg::SAMPLE_BITS;
    localparam int NS     = csc_pkg::NORM_STEPS;
    localparam int LOG_W  = csc_pkg::LOG_W;

    t_state r_state;

    // Configuration registers.
    logic                   r_enable;
    csc_pkg::t_settings     r_settings [csc_pkg::STAGES];

    // Envelope memory with one valid bit per entry; an invalid entry reads as zero.
    logic [ENV_W-1:0]           r_env_mem [csc_pkg::STAGES];
    logic [csc_pkg::STAGES-1:0] r_env_vld;
    logic [ENV_W-1:0]           r_env_rd;
    logic                       r_env_rd_vld;

    // Working registers.
    logic [csc_pkg::STAGE_W-1:0]        r_stage;
    logic signed [SB-1:0]               r_l;
    logic signed [SB-1:0]               r_r;
    logic                               r_blk;
    logic [ENV_W-1:0]                   r_level;
    logic [ENV_W+11:0]                  r_p1;
    logic [ENV_W-1:0]                   r_nx;
    logic [ENV_W-1:0]                   r_nt;
    logic [NS-1:0]                      r_ex;
    logic [NS-1:0]                      r_et;
    logic [csc_pkg::NCNT_W-1:0]         r_ncnt;
    logic [LOG_W-1:0]                   r_d;
    logic [LOG_W-1:0]                   r_a;
    logic [csc_pkg::GAIN_W-1:0]         r_g;
    logic [csc_pkg::PROD_W-1:0]         r_prod;

    csc_pkg::t_settings                 cur;
    logic                               last_stage;
    logic                               in_xfer;
    logic                               out_load;

    logic signed [SB:0]                 sum;
    logic [SB:0]                        mag;
    logic [ENV_W-1:0]                   level_c;
    logic [ENV_W-1:0]                   env_c;
    logic [11:0]                        coef;
    logic [ENV_W+12:0]                  p2;
    logic [ENV_W+13:0]                  env_sum;
    logic [ENV_W-1:0]                   env_new;
    logic [ENV_W-1:0]                   x_sel;
    logic [ENV_W-1:0]                   thr_env;
    logic                               gain_bypass;

    logic [NS-1:0]                      step_amt;
    logic                               nx_top_zero;
    logic                               nt_top_zero;

    logic [LOG_W-1:0]                   lx;
    logic [LOG_W-1:0]                   lt;
    logic [LOG_W+7:0]                   ds;
    logic [NS-1:0]                      ep;
    logic [15:0]                        eq;
    logic [NS:0]                        esh;
    logic [17:0]                        mant;
    logic [csc_pkg::GAIN_W-1:0]         g_c;

    logic signed [SB-1:0]               mul_in;
    logic signed [csc_pkg::MUL_W-1:0]   mul_full;
    logic signed [csc_pkg::MUL_W-1:0]   mul_rnd;
    logic signed [SB-1:0]               mul_sat;

    assign cur        = r_settings[r_stage];
    assign last_stage = (r_stage == csc_pkg::STAGE_W'(csc_pkg::STAGES - 1));
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    // Level of the pair entering this stage, in envelope format.
    always_comb begin
        sum     = SB'(0) + {r_l[SB-1], r_l} + {r_r[SB-1], r_r};
        mag     = sum[SB] ? (SB+1)'(-sum) : sum;
        level_c = {mag, 11'b0};
    end

    // Attack/release follower.
    always_comb begin
        env_c   = r_env_rd_vld ? r_env_rd : '0;
        coef    = (r_level > env_c) ? cur.attack_pole : cur.release_pole;
        p2      = (13'd4096 - {1'b0, coef}) * r_level;
        env_sum = (ENV_W+14)'(r_p1) + (ENV_W+14)'(p2);
        env_new = ENV_W'(env_sum >> 12);
    end

    // Detector value and the decision whether the gain computer is needed at all.
    always_comb begin
        x_sel       = (r_state == S_LEVEL) ? level_c : env_new;
        thr_env     = ENV_W'(cur.threshold) << (SB - 4);
        gain_bypass = (cur.threshold == 16'd0) || (x_sel <= thr_env);
    end

    // One step of the leading zero search on both detector and threshold.
    always_comb begin
        step_amt    = NS'(1) << (NS - 1 - int'(r_ncnt));
        nx_top_zero = ((r_nx >> (ENV_W - int'(step_amt))) == '0);
        nt_top_zero = ((r_nt >> (ENV_W - int'(step_amt))) == '0);
    end

    // Log difference, slope and exponent.
    always_comb begin
        lx   = {r_ex, 16'b0} + LOG_W'(csc_pkg::log2_interp(r_nx[ENV_W-2 -: 16]));
        lt   = {r_et, 16'b0} + LOG_W'(csc_pkg::log2_interp(r_nt[ENV_W-2 -: 16]));
        ds   = r_d * cur.slope;
        ep   = r_a[LOG_W-1:16];
        eq   = r_a[15:0];
        if (eq == 16'd0) begin
            esh  = {1'b0, ep};
            mant = 18'd65536;
        end else begin
            esh  = {1'b0, ep} + (NS+1)'(1);
            mant = csc_pkg::exp2_interp(16'(17'd65536 - {1'b0, eq}));
        end
        if (int'(esh) >= csc_pkg::GAIN_SHIFT_LIM) begin
            g_c = '0;
        end else begin
            g_c = csc_pkg::GAIN_W'(mant >> esh);
        end
    end

    // Shared scaling multiplier: left channel first, then right.
    always_comb begin
        mul_in   = (r_state == S_MUL_L) ? r_l : r_r;
        mul_full = mul_in * $signed({1'b0, r_prod});
        mul_rnd  = (mul_full + (csc_pkg::MUL_W'(1) <<< 27)) >>> 28;
        mul_sat  = csc_pkg::sat_sample(mul_rnd[csc_pkg::SCL_W-1:0]);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            for (int k = 0; k < csc_pkg::STAGES; k++) begin
                r_settings[k] <= csc_pkg::SETTINGS_RESET;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == csc_pkg::REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end else if (i_cfg_idx >= csc_pkg::REG_STAGE0 &&
                         int'(i_cfg_idx) <= csc_pkg::STAGES) begin
                r_settings[csc_pkg::STAGE_W'(i_cfg_idx - csc_pkg::REG_STAGE0)] <= i_cfg_data;
            end
        end
    end

    // Envelope memory: registered read in the level cycle, write in the update cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LEVEL) begin
            r_env_rd <= r_env_mem[r_stage];
        end
        if (r_state == S_ENV_UPD) begin
            r_env_mem[r_stage] <= env_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_vld    <= '0;
            r_env_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_LEVEL) begin
                r_env_rd_vld <= r_env_vld[r_stage];
            end
            if (r_state == S_ENV_UPD) begin
                r_env_vld[r_stage] <= 1'b1;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_ncnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_stage <= '0;
                        r_state <= r_enable ? S_LEVEL : S_DONE;
                    end
                end
                S_LEVEL: begin
                    if (!cur.instant) begin
                        r_state <= S_ENV_MUL;
                    end else if (gain_bypass) begin
                        r_state <= S_PROD;
                    end else begin
                        r_ncnt  <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_ENV_MUL: begin
                    r_state <= S_ENV_UPD;
                end
                S_ENV_UPD: begin
                    r_ncnt  <= '0;
                    r_state <= gain_bypass ? S_PROD : S_NORM;
                end
                S_NORM: begin
                    r_ncnt <= r_ncnt + csc_pkg::NCNT_W'(1);
                    if (r_ncnt == csc_pkg::NCNT_W'(NS - 1)) begin
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_state <= S_SLOPE;
                end
                S_SLOPE: begin
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_state <= S_MUL_L;
                end
                S_MUL_L: begin
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    if (last_stage) begin
                        r_state <= S_DONE;
                    end else begin
                        r_stage <= r_stage + csc_pkg::STAGE_W'(1);
                        r_state <= S_LEVEL;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_l   <= i_in_data.left_in;
            r_r   <= i_in_data.right_sample_in;
            r_blk <= i_in_data.block_end_in;
        end
        if (r_state == S_LEVEL) begin
            r_level <= level_c;
        end
        if (r_state == S_ENV_MUL) begin
            r_p1 <= coef * env_c;
        end
        if ((r_state == S_LEVEL && cur.instant) || r_state == S_ENV_UPD) begin
            r_nx <= x_sel;
            r_nt <= thr_env;
            r_ex <= NS'(ENV_W - 1);
            r_et <= NS'(ENV_W - 1);
            r_g  <= csc_pkg::GAIN_W'(17'd65536);
        end
        if (r_state == S_NORM) begin
            if (nx_top_zero) begin
                r_nx <= r_nx << step_amt;
                r_ex <= r_ex - step_amt;
            end
            if (nt_top_zero) begin
                r_nt <= r_nt << step_amt;
                r_et <= r_et - step_amt;
            end
        end
        if (r_state == S_LOG) begin
            r_d <= lx - lt;
        end
        if (r_state == S_SLOPE) begin
            r_a <= LOG_W'(ds >> 8);
        end
        if (r_state == S_EXP) begin
            r_g <= g_c;
        end
        if (r_state == S_PROD) begin
            r_prod <= r_g * cur.makeup;
        end
        if (r_state == S_MUL_L) begin
            r_l <= mul_sat;
        end
        if (r_state == S_MUL_R) begin
            r_r <= mul_sat;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_data.left_out      <= r_l;
            o_out_data.right_out     <= r_r;
            o_out_data.block_end_out <= r_blk;
        end
    end

    // An accepted transfer always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    // The envelope is only updated by a stage in envelope mode.
    a_env_write_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENV_UPD) |-> (!cur.instant && r_enable))
        else $error("envelope written by an instant or disabled stage");

    // A new result appears only out of the done state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output became valid outside the done state");

    // Stages advance one at a time.
    a_stage_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_R && !last_stage) |=>
            (r_stage == $past(r_stage) + csc_pkg::STAGE_W'(1)))
        else $error("stage counter skipped");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the cascaded stereo compressor.
`timescale 1ns / 100ps

// Holds the expected compressed samples and checks each result against the oldest one.
class compressed_pair_book;
    csc_pkg::t_out   pending[$];
    int              fail_count;
    int              checked;

    function void note_sample(csc_pkg::t_out exp_out);
        pending.push_back(exp_out);
    endfunction

    function void check_result(csc_pkg::t_out got);
        csc_pkg::t_out want;
        if (pending.size() == 0) begin
            $error("unexpected result: left %0d right %0d", got.left_out, got.right_out);
            fail_count++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.left_out !== want.left_out) begin
            $error("left_out: expected %0d, actual %0d", want.left_out, got.left_out);
            fail_count++;
        end
        if (got.right_out !== want.right_out) begin
            $error("right_out: expected %0d, actual %0d", want.right_out, got.right_out);
            fail_count++;
        end
        if (got.block_end_out !== want.block_end_out) begin
            $error("block_end_out: expected %0b, actual %0b",
                   want.block_end_out, got.block_end_out);
            fail_count++;
        end
    endfunction
endclass

module tb_top;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    csc_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    csc_pkg::t_out                  o_out_data;
    logic                           i_cfg_wr_en;
    logic [csc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [csc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state: a private copy of the registers and the envelope followers.
    logic                           pred_enable;
    logic [63:0]                    pred_settings [csc_pkg::STAGES];
    logic [csc_pkg::ENV_W-1:0]      pred_env [csc_pkg::STAGES];

    compressed_pair_book   book;
    int                    in_count;
    bit                    calm;  // When set, neither side idles.

    cascaded_stereo_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded by a timeout; the test sends about 820 items.
    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

    // Log2 in Q.16 of a nonzero value: MSB position plus interpolated fraction.
    function automatic longint unsigned log2_fix(longint unsigned x);
        int              msb;
        longint unsigned norm;
        longint unsigned frac;
        int              idx;
        longint unsigned lo_v;
        longint unsigned hi_v;
        longint unsigned lg_tab [17];
        lg_tab = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                   42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
        msb = 63;
        while (msb > 0 && x[msb] == 1'b0) msb--;
        norm = x << (63 - msb);
        frac = (norm >> 47) & 64'hFFFF;
        idx  = int'(frac >> 12);
        lo_v = lg_tab[idx];
        hi_v = lg_tab[idx + 1];
        return (longint'(msb) << 16) + lo_v + (((hi_v - lo_v) * (frac & 64'hFFF)) >> 12);
    endfunction

    function automatic longint unsigned exp2_fix(longint unsigned u);
        longint unsigned ex_tab [17];
        int              idx;
        ex_tab = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
                   96785, 101070, 105544, 110218, 115098, 120194, 125515, 131072};
        idx = int'((u >> 12) & 4'hF);
        return ex_tab[idx] + (((ex_tab[idx + 1] - ex_tab[idx]) * (u & 64'hFFF)) >> 12);
    endfunction

    // Gain in Q1.16 for detector level x against a 16-bit threshold.
    function automatic longint unsigned stage_gain_of(longint unsigned x,
                                                      longint unsigned thr,
                                                      longint unsigned slope);
        longint unsigned thr_lvl;
        longint unsigned atten;
        longint unsigned sh;
        longint unsigned mant;
        if (thr == 0) return 65536;
        thr_lvl = thr << (csc_pkg::SAMPLE_BITS - 4);
        if (x <= thr_lvl) return 65536;
        atten = ((log2_fix(x) - log2_fix(thr_lvl)) * slope) >> 8;
        if ((atten & 64'hFFFF) == 0) begin
            mant = 65536;
            sh   = atten >> 16;
        end else begin
            mant = exp2_fix(65536 - (atten & 64'hFFFF));
            sh   = (atten >> 16) + 1;
        end
        if (sh >= 32) return 0;
        return mant >> sh;
    endfunction

    function automatic longint clamp_sample(longint v);
        longint hi;
        hi = (longint'(1) << (csc_pkg::SAMPLE_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Runs one sample pair through the stage chain and updates the envelopes.
    function automatic csc_pkg::t_out compress_pair(csc_pkg::t_in smp);
        csc_pkg::t_out      res;
        longint             lv;
        longint             rv;
        longint             sum;
        longint unsigned    lvl;
        longint unsigned    x;
        longint unsigned    coef;
        longint unsigned    g;
        longint             scale;
        csc_pkg::t_settings st;
        lv = longint'(smp.left_in);
        rv = longint'(smp.right_sample_in);
        if (pred_enable) begin
            for (int k = 0; k < csc_pkg::STAGES; k++) begin
                st  = csc_pkg::t_settings'(pred_settings[k]);
                sum = lv + rv;
                lvl = longint'(sum < 0 ? -sum : sum) << 11;
                if (st.instant) begin
                    x = lvl;
                end else begin
                    coef = (lvl > pred_env[k]) ? st.attack_pole : st.release_pole;
                    x = (coef * pred_env[k] + (4096 - coef) * lvl) >> 12;
                    pred_env[k] = csc_pkg::ENV_W'(x);
                end
                g     = stage_gain_of(x, st.threshold, st.slope);
                scale = longint'(g * st.makeup);
                // Arithmetic right shift is a floor division by 2^28.
                lv = clamp_sample((lv * scale + (longint'(1) << 27)) >>> 28);
                rv = clamp_sample((rv * scale + (longint'(1) << 27)) >>> 28);
            end
        end
        res.left_out      = csc_pkg::SAMPLE_BITS'(lv);
        res.right_out     = csc_pkg::SAMPLE_BITS'(rv);
        res.block_end_out = smp.block_end_in;
        return res;
    endfunction

    function automatic logic [csc_pkg::CFG_IDX_W-1:0] stage_reg(int k);
        return csc_pkg::REG_STAGE0 + csc_pkg::CFG_IDX_W'(k);
    endfunction

    // One write; the write enable is then lowered again before the task returns.
    task automatic write_reg(input logic [csc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == csc_pkg::REG_ENABLE) begin
            pred_enable = val[0];
        end else if (idx - csc_pkg::REG_STAGE0 < csc_pkg::STAGES) begin
            pred_settings[idx - csc_pkg::REG_STAGE0] = val;
        end
        @(posedge i_clk);
    endtask

    // Offers one sample pair and holds it until the transfer happens. Valid stays
    // high afterwards; the next call or the caller lowers it.
    task automatic send_pair(input csc_pkg::t_in smp);
        if (!calm) begin
            while ($urandom_range(99) < 26) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.note_sample(compress_pair(smp));
        in_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        // A pair may not be finished before the next write, so give the datapath time.
        repeat (80) @(posedge i_clk);
    endtask

    function automatic csc_pkg::t_in make_pair(longint l, longint r, bit be);
        csc_pkg::t_in p;
        p.left_in         = csc_pkg::SAMPLE_BITS'(l);
        p.right_sample_in = csc_pkg::SAMPLE_BITS'(r);
        p.block_end_in    = be;
        return p;
    endfunction

    function automatic logic [63:0] pack_settings(int thr, int slope, int att, int rel,
                                                  int mk, bit inst);
        csc_pkg::t_settings s;
        s.threshold    = 16'(thr);
        s.slope        = 8'(slope);
        s.attack_pole  = 12'(att);
        s.release_pole = 12'(rel);
        s.makeup       = 15'(mk);
        s.instant      = inst;
        return 64'(s);
    endfunction

    function automatic logic [63:0] random_settings();
        return pack_settings($urandom_range(3) == 0 ? 0 : $urandom_range(16'hFFFF) >>
                                 $urandom_range(12),
                             $urandom_range(255), $urandom_range(4095),
                             $urandom_range(4095),
                             $urandom_range(3) == 0 ? $urandom_range(32767)
                                                    : $urandom_range(3000, 6000),
                             $urandom_range(1));
    endfunction

    // Mostly loud and quiet program material, with some full scale noise.
    function automatic csc_pkg::t_in random_pair();
        longint amp;
        case ($urandom_range(3))
            0: amp = 8388607;
            1: amp = 1 << $urandom_range(22);
            default: amp = $urandom_range(8388607) >> $urandom_range(4);
        endcase
        return make_pair($urandom_range(2 * amp) - amp, $urandom_range(2 * amp) - amp,
                         $urandom_range(7) == 0);
    endfunction

    // The receiver stalls independently of the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                book.check_result(o_out_data);
            end
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    initial begin
        logic [63:0] sv;
        book        = new();
        calm        = 1'b0;
        in_count    = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        pred_enable = 1'b1;
        for (int k = 0; k < csc_pkg::STAGES; k++) begin
            pred_settings[k] = csc_pkg::SETTINGS_RESET;
            pred_env[k]      = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings: extremes, silence and block marks.
        send_pair(make_pair(0, 0, 0));
        send_pair(make_pair(8388607, 8388607, 1));
        send_pair(make_pair(-8388608, -8388608, 0));
        send_pair(make_pair(8388607, -8388608, 1));
        send_pair(make_pair(-8388608, 8388607, 0));
        send_pair(make_pair(1, -1, 0));
        send_pair(make_pair(-1, -1, 1));
        drain();

        // Instant mode, zero threshold, mute, full makeup and steep slope.
        write_reg(stage_reg(0), pack_settings(0, 255, 0, 0, 4096, 1));
        write_reg(stage_reg(1), pack_settings(1, 255, 4095, 4095, 32767, 1));
        write_reg(stage_reg(2), pack_settings(16'hFFFF, 128, 4095, 0, 4096, 0));
        write_reg(stage_reg(3), pack_settings(100, 200, 100, 4000, 8192, 0));
        send_pair(make_pair(8388607, 8388607, 0));
        send_pair(make_pair(-8388608, -8388608, 1));
        send_pair(make_pair(3000, 2000, 0));
        send_pair(make_pair(0, 0, 0));
        drain();
        write_reg(stage_reg(1), pack_settings(200, 64, 10, 10, 0, 0));
        send_pair(make_pair(4000000, -100, 1));
        send_pair(make_pair(-7000000, 5, 0));
        drain();
        // Bypass: the outputs copy the inputs and the followers hold.
        write_reg(csc_pkg::REG_ENABLE, 64'd0);
        send_pair(make_pair(8388607, -8388608, 1));
        send_pair(make_pair(-12345, 6789, 0));
        drain();
        write_reg(csc_pkg::REG_ENABLE, 64'd1);
        write_reg(stage_reg(0), 64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(make_pair(8388607, 8388607, 0));
        send_pair(make_pair(-2, 1, 1));
        drain();

        // Random phases, each with fresh settings; the fourth runs with no idling.
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            for (int k = 0; k < csc_pkg::STAGES; k++) begin
                sv = random_settings();
                write_reg(stage_reg(k), sv);
            end
            write_reg(csc_pkg::REG_ENABLE, 64'($urandom_range(5) != 0));
            for (int n = 0; n < 100; n++) begin
                send_pair(random_pair());
                // Once, in the second phase, the sender waits for the whole backlog to clear.
                if (n == 50 && ph == 1) begin
                    i_in_valid <= 1'b0;
                    while (book.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        calm = 1'b0;

        $display("tb_top: %0d sample pairs sent, %0d results checked over directed",
                 in_count, book.checked);
        $display("tb_top: corner cases and eight random register settings");
        if (book.fail_count == 0 && book.pending.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### cascaded_stereo_compressor.f
src/csc_pkg.sv
src/cascaded_stereo_compressor.sv
tb/tb_top.sv
